// ===== rtl/ake_pkg.sv =====
// ----------------------------------------------------------------------------
// ake_pkg
// Shared types, sizes and constant tables of the AES-128 key expansion block.
// ----------------------------------------------------------------------------
package ake_pkg;

	localparam int KEY_W    = 128;
	localparam int HALF_W   = 64;
	localparam int RND_W    = 4;
	localparam int NUM_RK   = 11;
	localparam logic [RND_W-1:0] LAST_RND = 4'd10;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [RND_W-1:0] rnd_t;

	// One pipeline slot: a round key and the flag that says it is occupied.
	typedef struct packed {
		logic vld;
		key_t key;
	} stage_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX[b];
	endfunction

	// Round constant for rounds 1 to 10; other codes never reach it.
	function automatic logic [7:0] rcon(input rnd_t rnd);
		logic [7:0] rc;
		unique case (rnd)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1b;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

endpackage

// ===== rtl/ake_if.sv =====
// ----------------------------------------------------------------------------
// ake_if
// Valid/ready channels of the key expansion block: cipher keys in, round keys out.
// ----------------------------------------------------------------------------
interface ake_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_upper;
	logic [63:0] key_lower;

	modport source (output valid, output key_upper, output key_lower, input ready);
	modport sink   (input valid, input key_upper, input key_lower, output ready);
endinterface

interface ake_rk_if;
	logic        valid;
	logic        ready;
	logic [3:0]  round_number;
	logic [63:0] round_key_upper;
	logic [63:0] round_key_lower;
	logic        last_round;

	modport source (output valid, output round_number, output round_key_upper,
		output round_key_lower, output last_round, input ready);
	modport sink   (input valid, input round_number, input round_key_upper,
		input round_key_lower, input last_round, output ready);
endinterface

// ===== rtl/ake_in_buf.sv =====
// ----------------------------------------------------------------------------
// ake_in_buf
// One-entry holding register for an incoming cipher key request.
// ----------------------------------------------------------------------------
module ake_in_buf (
	input  logic            clk,
	input  logic            arst_n,
	ake_key_if.sink         req,
	input  logic            take,
	output ake_pkg::stage_t held
);

	logic          vld_q;
	ake_pkg::key_t key_q;
	logic          acc;

	// The entry frees up in the same cycle it is handed on.
	assign req.ready = !vld_q || take;
	assign acc       = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (acc) begin
			vld_q <= 1'b1;
		end else if (take) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= {req.key_upper, req.key_lower};
		end
	end

	assign held = '{vld: vld_q, key: key_q};

endmodule

// ===== rtl/ake_round.sv =====
// ----------------------------------------------------------------------------
// ake_round
// One key schedule round as a register stage: RotWord, SubWord, Rcon, XOR chain.
// ----------------------------------------------------------------------------
module ake_round (
	input  logic            clk,
	input  logic            arst_n,
	input  ake_pkg::rnd_t   rnd,
	input  logic            adv,
	input  ake_pkg::stage_t prev,
	output ake_pkg::stage_t cur
);

	logic          vld_s1;
	ake_pkg::key_t key_s1;
	logic [31:0]   w0, w1, w2, w3;
	logic [31:0]   tmp;
	logic [31:0]   n0, n1, n2, n3;

	assign {w0, w1, w2, w3} = prev.key;

	// Rotate the last word by one byte, substitute each byte, fold in the constant.
	assign tmp = {ake_pkg::sbox(w3[23:16]) ^ ake_pkg::rcon(rnd),
		ake_pkg::sbox(w3[15:8]),
		ake_pkg::sbox(w3[7:0]),
		ake_pkg::sbox(w3[31:24])};

	assign n0 = w0 ^ tmp;
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s1 <= {n0, n1, n2, n3};
		end
	end

	assign cur = '{vld: vld_s1, key: key_s1};

endmodule

// ===== rtl/aes128_key_expansion.sv =====
// ----------------------------------------------------------------------------
// aes128_key_expansion
// AES-128 key schedule: one cipher key in, the eleven round keys out in order.
// ----------------------------------------------------------------------------
// Each accepted cipher key request produces eleven round key requests, rounds 0
// through 10, with last_round set on round 10. The keys run through a chain of
// eleven slots: slot 0 holds the cipher key itself and each of the ten round
// stages behind it computes the next round key (four S-box lookups and the word
// XOR chain) as the key moves along. A key sits in exactly one slot at a time,
// and that slot drives the output, so the slots themselves are the output
// register. The chain steps forward only when the current round key is taken,
// which gives one round key per cycle on an unstalled output, all eleven round
// keys of a cipher key leaving through the single result channel. A
// one-entry input register accepts the next cipher key while the current one
// is still being delivered, and it enters slot 0 in the same cycle that round
// 10 of the previous key is taken, so consecutive keys stream with no gap.
// In an empty block an accepted key goes through the input register to slot 0.
// Nothing is kept from one key to the next; reset clears only the valid flags.
// ----------------------------------------------------------------------------
module aes128_key_expansion (
	input  logic       clk,
	input  logic       arst_n,
	ake_key_if.sink    cipher_key,
	ake_rk_if.source   round_key
);

	ake_pkg::stage_t held;
	ake_pkg::stage_t stage [ake_pkg::NUM_RK];
	logic            vld_s0;
	ake_pkg::key_t   key_s0;
	logic            load;
	logic            adv;
	logic            early_busy;
	logic            any_vld;
	ake_pkg::key_t   sel_key;
	ake_pkg::rnd_t   sel_rnd;

	// Input holding register, drained into slot 0 by load.
	ake_in_buf u_in_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cipher_key),
		.take   (load),
		.held   (held)
	);

	// The whole chain steps when the current round key request is taken.
	assign adv = round_key.valid && round_key.ready;

	// A new key may enter only once the previous one has left slots 0 to 9 and
	// its round 10 key, if still present, leaves in this cycle.
	assign load = held.vld && !early_busy && (!stage[ake_pkg::NUM_RK-1].vld || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (load) begin
			vld_s0 <= 1'b1;
		end else if (adv) begin
			vld_s0 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_s0 <= held.key;
		end
	end

	assign stage[0] = '{vld: vld_s0, key: key_s0};

	// Ten round stages, each one key schedule round further along.
	for (genvar k = 1; k < ake_pkg::NUM_RK; k++) begin : g_round
		ake_round u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.rnd    (ake_pkg::RND_W'(k)),
			.adv    (adv),
			.prev   (stage[k-1]),
			.cur    (stage[k])
		);
	end

	// At most one slot is occupied, so the output is a plain AND-OR select and
	// the round number is the index of that slot.
	always_comb begin
		any_vld    = 1'b0;
		early_busy = 1'b0;
		sel_key    = '0;
		sel_rnd    = '0;
		for (int k = 0; k < ake_pkg::NUM_RK; k++) begin
			if (stage[k].vld) begin
				any_vld = 1'b1;
				sel_key = sel_key | stage[k].key;
				sel_rnd = sel_rnd | ake_pkg::RND_W'(k);
				if (k < ake_pkg::NUM_RK - 1) begin
					early_busy = 1'b1;
				end
			end
		end
	end

	assign round_key.valid           = any_vld;
	assign round_key.round_number    = sel_rnd;
	assign round_key.round_key_upper = sel_key[ake_pkg::KEY_W-1:ake_pkg::HALF_W];
	assign round_key.round_key_lower = sel_key[ake_pkg::HALF_W-1:0];
	assign round_key.last_round      = stage[ake_pkg::NUM_RK-1].vld;

endmodule

// ===== rtl/ake_checker.sv =====
// ----------------------------------------------------------------------------
// ake_checker
// Port-level checks on the round key sequence of the key expansion block.
// ----------------------------------------------------------------------------
module ake_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rk_valid,
	input logic        rk_ready,
	input logic [3:0]  rk_round,
	input logic [63:0] rk_upper,
	input logic [63:0] rk_lower,
	input logic        rk_last
);

	logic rk_take;

	assign rk_take = rk_valid && rk_ready;

	// The last flag marks round 10 and nothing else, and no round goes beyond it.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid |-> (rk_last == (rk_round == ake_pkg::LAST_RND))
			&& (rk_round <= ake_pkg::LAST_RND))
		else $error("last_round does not match round_number");

	// Within a key, the next round follows right after the previous one is taken.
	a_next_round: assert property (@(posedge clk) disable iff (!arst_n)
		rk_take && !rk_last |=> rk_valid
			&& (rk_round == ake_pkg::RND_W'($past(rk_round) + 4'd1)))
		else $error("round key sequence broken");

	// After round 10 the next request, if any, starts a new key at round 0.
	a_new_key: assert property (@(posedge clk) disable iff (!arst_n)
		rk_take && rk_last |=> !rk_valid || (rk_round == 4'd0))
		else $error("new key does not start at round 0");

	// A stalled round key request holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid && !rk_ready |=> rk_valid && $stable(rk_round)
			&& $stable(rk_upper) && $stable(rk_lower))
		else $error("stalled round key changed");

endmodule

bind aes128_key_expansion ake_checker u_ake_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rk_valid (round_key.valid),
	.rk_ready (round_key.ready),
	.rk_round (round_key.round_number),
	.rk_upper (round_key.round_key_upper),
	.rk_lower (round_key.round_key_lower),
	.rk_last  (round_key.last_round)
);

// ===== verif/ake_round_key_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_round_key_checker
// Watches both channels of the key expansion block and checks every round key.
// Each accepted cipher key request is expanded here into its eleven round keys.
// Each round key request from the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module ake_round_key_checker (
	input  logic  clk,
	input  logic  arst_n,
	ake_key_if    cipher_key,
	ake_rk_if     round_key,
	output int    failures,
	output int    pending
);

	typedef struct {
		ake_pkg::rnd_t rnd;
		logic [63:0]   upper;
		logic [63:0]   lower;
		logic          last;
	} round_key_t;

	localparam logic [7:0] SUB_BYTE [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] ROUND_CONST [1:10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	round_key_t expected_round_keys[$];
	int         error_count = 0;

	assign failures = error_count;

	// One step of the AES-128 schedule; word 0 sits in the top 32 bits.
	function automatic ake_pkg::key_t expand_round(input ake_pkg::key_t prev, input int rnd);
		logic [31:0]   w0, w1, w2, w3, t;
		ake_pkg::key_t nxt;
		w0 = prev[127:96];
		w1 = prev[95:64];
		w2 = prev[63:32];
		w3 = prev[31:0];
		t  = {SUB_BYTE[w3[23:16]] ^ ROUND_CONST[rnd], SUB_BYTE[w3[15:8]],
			SUB_BYTE[w3[7:0]], SUB_BYTE[w3[31:24]]};
		nxt[127:96] = w0 ^ t;
		nxt[95:64]  = w1 ^ nxt[127:96];
		nxt[63:32]  = w2 ^ nxt[95:64];
		nxt[31:0]   = w3 ^ nxt[63:32];
		return nxt;
	endfunction

	task automatic queue_schedule(input logic [63:0] upper, input logic [63:0] lower);
		ake_pkg::key_t cur;
		round_key_t    rk;
		cur = {upper, lower};
		for (int r = 0; r < ake_pkg::NUM_RK; r++) begin
			if (r > 0)
				cur = expand_round(cur, r);
			rk.rnd   = ake_pkg::rnd_t'(r);
			rk.upper = cur[127:64];
			rk.lower = cur[63:0];
			rk.last  = (ake_pkg::rnd_t'(r) == ake_pkg::LAST_RND);
			expected_round_keys.push_back(rk);
		end
	endtask

	task automatic check_round_key();
		round_key_t exp_rk;
		if (expected_round_keys.size() == 0) begin
			$display("%0t: unexpected round key request, round %0d upper %h lower %h",
				$time, round_key.round_number, round_key.round_key_upper,
				round_key.round_key_lower);
			error_count++;
			return;
		end
		exp_rk = expected_round_keys.pop_front();
		if (round_key.round_number !== exp_rk.rnd) begin
			$display("%0t: round_number expected %0d actual %0d",
				$time, exp_rk.rnd, round_key.round_number);
			error_count++;
		end
		if (round_key.round_key_upper !== exp_rk.upper) begin
			$display("%0t: round %0d round_key_upper expected %h actual %h",
				$time, exp_rk.rnd, exp_rk.upper, round_key.round_key_upper);
			error_count++;
		end
		if (round_key.round_key_lower !== exp_rk.lower) begin
			$display("%0t: round %0d round_key_lower expected %h actual %h",
				$time, exp_rk.rnd, exp_rk.lower, round_key.round_key_lower);
			error_count++;
		end
		if (round_key.last_round !== exp_rk.last) begin
			$display("%0t: round %0d last_round expected %b actual %b",
				$time, exp_rk.rnd, exp_rk.last, round_key.last_round);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_round_keys.delete();
			pending <= 0;
		end else begin
			if (cipher_key.valid && cipher_key.ready)
				queue_schedule(cipher_key.key_upper, cipher_key.key_lower);
			if (round_key.valid && round_key.ready)
				check_round_key();
			pending <= expected_round_keys.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the AES-128 key expansion block.
// A directed set of cipher keys (all zeros, all ones, the standard test key,
// sparse and patterned keys) is followed by random keys, with random idle
// gaps on the cipher key side and random stalls on the round key side. A
// separate checker predicts and compares every round key.
// ----------------------------------------------------------------------------
module tb_top;

	// Generous ceiling on the whole run; the slowest legal run is far shorter.
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int RANDOM_KEYS   = 106;
	localparam int SETTLE_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   pending;

	ake_key_if key_ch ();
	ake_rk_if  rk_ch ();

	always #5 clk = ~clk;

	aes128_key_expansion DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cipher_key (key_ch),
		.round_key  (rk_ch)
	);

	ake_round_key_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cipher_key (key_ch),
		.round_key  (rk_ch),
		.failures   (failures),
		.pending    (pending)
	);

	// Idle gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// One half of a random cipher key. Most halves are dense random data;
	// the rest are sparse or patterned so that S-box inputs near zero and
	// near all ones turn up often in the last word.
	function automatic logic [63:0] random_half();
		int          r;
		logic [63:0] v;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				v = '0;
				v[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
			end
			1: begin
				v = '1;
				v[$urandom_range(0, 63)] = 1'b0;
			end
			2: v = {8{8'($urandom)}};
			default: v = {32'($urandom), 32'($urandom)};
		endcase
		return v;
	endfunction

	// Present one cipher key request and hold it until the block takes it.
	// When the request follows the previous one back to back, valid simply
	// stays high, so it is never lowered and raised in the same time step.
	task automatic send_key(input logic [63:0] upper, input logic [63:0] lower,
		input bit allow_gap);
		int gap;
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_ch.valid     <= 1'b1;
		key_ch.key_upper <= upper;
		key_ch.key_lower <= lower;
		do
			@(posedge clk);
		while (!key_ch.ready);
	endtask

	// Hold off new requests until every expected round key has come out.
	// The first edge lets the checker count the request accepted last.
	task automatic wait_for_drain();
		key_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result side: ready runs high for a while, then drops for a random gap.
	// A zero gap keeps ready high, which gives long stall-free stretches.
	initial begin
		int run_len;
		int gap;
		rk_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		rk_ch.ready <= 1'b1;
		forever begin
			run_len = $urandom_range(1, 24);
			repeat (run_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rk_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rk_ch.ready <= 1'b1;
			end
		end
	end

	// Main stimulus: reset, directed keys, a full drain, random keys with a
	// second drain halfway through, then the final wait and the verdict.
	initial begin
		bit burst;
		key_ch.valid     <= 1'b0;
		key_ch.key_upper <= '0;
		key_ch.key_lower <= '0;
		arst_n           <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of both halves.
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
		send_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
		send_key(64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000, 1'b0);
		send_key(64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 1'b1);
		// The standard AES-128 example key and a counting pattern.
		send_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c, 1'b1);
		send_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 1'b0);
		// Alternating bit patterns, both ways round.
		send_key(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		send_key(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
		// Single bytes in the last word, which feeds the S-box in round 1.
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_ff00_0000, 1'b1);
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_00ff_0000, 1'b0);
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_0000_ff00, 1'b1);
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_0000_00ff, 1'b0);
		// Top and bottom bit of the key alone.
		send_key(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
		send_key(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);

		// Let everything come out before the random part starts.
		wait_for_drain();

		burst = 1'b0;
		for (int i = 0; i < RANDOM_KEYS; i++) begin
			// Every so often switch between gapped and back-to-back requests.
			if (i % 15 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_KEYS / 2)
				wait_for_drain();
			send_key(random_half(), random_half(), !burst);
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ake_pkg.sv
rtl/ake_if.sv
rtl/ake_in_buf.sv
rtl/ake_round.sv
rtl/aes128_key_expansion.sv
rtl/ake_checker.sv
verif/ake_round_key_checker.sv
verif/tb_top.sv
